// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ddshc_pkg.sv =====
// Types and constants for the DDS header checker
`timescale 1ns / 1ps
`default_nettype none

package ddshc_pkg;

   typedef struct packed {
      logic [31:0] word;
      logic        first;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] width;
      logic [31:0] height;
      logic        has_alpha;
      logic [2:0]  format;
      logic [4:0]  block_bytes;
      logic [31:0] row_bytes;
      logic [31:0] data_bytes;
      logic [2:0]  border_right;
      logic [2:0]  border_bottom;
   } rsp_type;

   // header state handed from the word checker to the size unit
   typedef struct packed {
      logic        at_last;
      logic [1:0]  fault;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] declared;
      logic [2:0]  format;
   } hdr_type;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_CORRUPT = 2'd1;
   localparam logic [1:0] FAULT_UNKNOWN = 2'd2;

   localparam logic [31:0] MAGIC_DDS   = 32'h2053_4444;
   localparam logic [31:0] FCC_DXT1    = 32'h3154_5844;
   localparam logic [31:0] FCC_DXT2    = 32'h3254_5844;
   localparam logic [31:0] FCC_DXT3    = 32'h3354_5844;
   localparam logic [31:0] FCC_DXT4    = 32'h3454_5844;
   localparam logic [31:0] FCC_DXT5    = 32'h3554_5844;
   localparam logic [31:0] FCC_DX10    = 32'h3031_5844;
   localparam logic [31:0] REQ_FLAGS   = 32'h0000_1007;
   localparam logic [31:0] OPT_FLAGS   = 32'h000A_0000;
   localparam logic [31:0] HDR_SIZE    = 32'd124;
   localparam logic [31:0] PF_SIZE     = 32'd32;
   localparam logic [32:0] HDR_BYTES   = 33'd128;
   localparam int          LINEAR_BIT  = 19;
   localparam int          FOURCC_BIT  = 2;
   localparam int          TEXTURE_BIT = 12;

   localparam logic [4:0] WORD_MAGIC   = 5'd0;
   localparam logic [4:0] WORD_SIZE    = 5'd1;
   localparam logic [4:0] WORD_FLAGS   = 5'd2;
   localparam logic [4:0] WORD_HEIGHT  = 5'd3;
   localparam logic [4:0] WORD_WIDTH   = 5'd4;
   localparam logic [4:0] WORD_LINEAR  = 5'd5;
   localparam logic [4:0] WORD_PFSIZE  = 5'd19;
   localparam logic [4:0] WORD_PFFLAGS = 5'd20;
   localparam logic [4:0] WORD_FOURCC  = 5'd21;
   localparam logic [4:0] WORD_CAPS    = 5'd27;
   localparam logic [4:0] WORD_CAPS2   = 5'd28;
   localparam logic [5:0] WORD_LAST    = 6'd31;

   localparam logic [2:0] FMT_DXT1_RGB  = 3'd0;
   localparam logic [2:0] FMT_DXT1_RGBA = 3'd1;
   localparam logic [2:0] FMT_DXT2      = 3'd2;
   localparam logic [2:0] FMT_DXT3      = 3'd3;
   localparam logic [2:0] FMT_DXT4      = 3'd4;
   localparam logic [2:0] FMT_DXT5      = 3'd5;

   localparam logic [4:0] BLOCK_DXT1  = 5'd8;
   localparam logic [4:0] BLOCK_OTHER = 5'd16;

endpackage

`default_nettype wire

// ===== rtl/ddshc_check.sv =====
// Word sequencer: per-word header checks and saved header fields
`timescale 1ns / 1ps
`default_nettype none

module ddshc_check
   import ddshc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_accept,
   input  wire req_type req_data,
   output hdr_type      hdr
);

   logic [5:0]  word_count_ff, word_count_in;
   logic [1:0]  fault_ff, fault_in;
   logic [31:0] height_ff, height_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] declared_ff, declared_in;
   logic        alpha_ff, alpha_in;
   logic [2:0]  format_ff, format_in;

   logic [5:0]  cnt;
   logic [1:0]  fault_base;
   logic [1:0]  code;
   logic [31:0] w;

   always_comb begin
      w          = req_data.word;
      cnt        = req_data.first ? 6'd0 : word_count_ff;
      fault_base = req_data.first ? FAULT_NONE : fault_ff;
      code       = FAULT_NONE;

      word_count_in = word_count_ff;
      fault_in      = fault_ff;
      height_in     = height_ff;
      width_in      = width_ff;
      declared_in   = declared_ff;
      alpha_in      = alpha_ff;
      format_in     = format_ff;

      if (req_accept) begin
         word_count_in = cnt;
         fault_in      = fault_base;
         if (!cnt[5]) begin
            unique case (cnt[4:0])
               WORD_MAGIC: begin
                  if (w != MAGIC_DDS) code = FAULT_CORRUPT;
               end
               WORD_SIZE: begin
                  if (w != HDR_SIZE) code = FAULT_CORRUPT;
               end
               WORD_FLAGS: begin
                  priority if ((w & REQ_FLAGS) != REQ_FLAGS) code = FAULT_CORRUPT;
                  else if ((w & ~OPT_FLAGS) != REQ_FLAGS) code = FAULT_UNKNOWN;
                  else if (!w[LINEAR_BIT]) code = FAULT_CORRUPT;
                  else code = FAULT_NONE;
               end
               WORD_HEIGHT: begin
                  height_in = w;
               end
               WORD_WIDTH: begin
                  width_in = w;
                  if (w == 32'd0 || height_ff == 32'd0) code = FAULT_CORRUPT;
               end
               WORD_LINEAR: begin
                  declared_in = w;
               end
               WORD_PFSIZE: begin
                  if (w != PF_SIZE) code = FAULT_CORRUPT;
               end
               WORD_PFFLAGS: begin
                  alpha_in = w[0];
                  if (!w[FOURCC_BIT]) code = FAULT_CORRUPT;
               end
               WORD_FOURCC: begin
                  priority if (w == FCC_DXT1)
                     format_in = alpha_ff ? FMT_DXT1_RGBA : FMT_DXT1_RGB;
                  else if (w == FCC_DXT2) format_in = FMT_DXT2;
                  else if (w == FCC_DXT3) format_in = FMT_DXT3;
                  else if (w == FCC_DXT4) format_in = FMT_DXT4;
                  else if (w == FCC_DXT5) format_in = FMT_DXT5;
                  else if (w == FCC_DX10) code = FAULT_UNKNOWN;
                  else code = FAULT_CORRUPT;
               end
               WORD_CAPS: begin
                  if (!w[TEXTURE_BIT]) code = FAULT_UNKNOWN;
               end
               WORD_CAPS2: begin
                  if (w != 32'd0) code = FAULT_UNKNOWN;
               end
               default: begin
                  code = FAULT_NONE;
               end
            endcase
            if (fault_base == FAULT_NONE) fault_in = code;
            // word 31 steps on to 32, the idle count
            word_count_in = cnt + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= 6'd0;
         fault_ff      <= FAULT_NONE;
         height_ff     <= 32'd0;
         width_ff      <= 32'd0;
         declared_ff   <= 32'd0;
         alpha_ff      <= 1'b0;
         format_ff     <= FMT_DXT1_RGB;
      end else begin
         word_count_ff <= word_count_in;
         fault_ff      <= fault_in;
         height_ff     <= height_in;
         width_ff      <= width_in;
         declared_ff   <= declared_in;
         alpha_ff      <= alpha_in;
         format_ff     <= format_in;
      end
   end

   always_comb begin
      hdr.at_last  = (word_count_ff == WORD_LAST);
      hdr.fault    = fault_ff;
      hdr.width    = width_ff;
      hdr.height   = height_ff;
      hdr.declared = declared_ff;
      hdr.format   = format_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/ddshc_size.sv =====
// Size unit: block counts, data size product and final status
`timescale 1ns / 1ps
`default_nettype none

module ddshc_size
   import ddshc_pkg::*;
(
   input  wire logic        clock,
   input  wire hdr_type     hdr,
   input  wire logic [31:0] file_bytes,
   output rsp_type          result
);

   logic [30:0] blocks_w;
   logic [30:0] blocks_h;
   logic [31:0] prod_ff;
   logic [31:0] prod_full;
   logic        dxt1;
   logic [4:0]  blk;
   logic [31:0] row;
   logic [31:0] data;
   logic        bad_size;
   logic [1:0]  st;

   always_comb begin
      blocks_w  = {1'b0, hdr.width[31:2]} + {30'd0, |hdr.width[1:0]};
      blocks_h  = {1'b0, hdr.height[31:2]} + {30'd0, |hdr.height[1:0]};
      // only the low 32 bits of the product matter
      prod_full = {1'b0, blocks_w} * {1'b0, blocks_h};
   end

   // width and height settle many items before word 31, so the product
   // is simply registered every cycle
   always_ff @(posedge clock) begin
      prod_ff <= prod_full;
   end

   always_comb begin
      dxt1 = (hdr.format == FMT_DXT1_RGB) || (hdr.format == FMT_DXT1_RGBA);
      blk  = dxt1 ? BLOCK_DXT1 : BLOCK_OTHER;
      row  = dxt1 ? {blocks_w[28:0], 3'd0} : {blocks_w[27:0], 4'd0};
      data = dxt1 ? {prod_ff[28:0], 3'd0} : {prod_ff[27:0], 4'd0};

      bad_size = (data != hdr.declared) ||
                 ({1'b0, file_bytes} < (HDR_BYTES + {1'b0, data}));

      priority if ({1'b0, file_bytes} <= HDR_BYTES) st = FAULT_CORRUPT;
      else if (hdr.fault != FAULT_NONE) st = hdr.fault;
      else if (bad_size) st = FAULT_CORRUPT;
      else st = FAULT_NONE;

      result        = '0;
      result.status = st;
      if (st == FAULT_NONE) begin
         result.width         = hdr.width;
         result.height        = hdr.height;
         result.has_alpha     = (hdr.format != FMT_DXT1_RGB);
         result.format        = hdr.format;
         result.block_bytes   = blk;
         result.row_bytes     = row;
         result.data_bytes    = data;
         result.border_right  = 3'd4 - {1'b0, hdr.width[1:0]};
         result.border_bottom = 3'd4 - {1'b0, hdr.height[1:0]};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dds_header_checker.sv =====
// DDS texture header checker top level
// Usage:
//  - req channel: one little-endian header word per item; first marks word 0
//    and restarts the count and fault, also in mid-header. Counting starts at
//    word 0 after reset even without first.
//  - rsp channel: one result per header, loaded into the output register the
//    cycle after word 31 is accepted. Words beyond 31 without first are
//    dropped and give nothing.
//  - csr channel: writes file_bytes, always ready; write it while idle.
//    It is sampled when word 31 is taken.
// Throughput: one word per cycle while req_ready is high; every check is a
// short compare on the current word, the block-count product is registered
// ahead of word 31.
// Stall: req_ready drops only when word 31 is next and the output register
// still holds a result the receiver has not taken; other words keep flowing.
// Reset (synchronous): count, fault and file_bytes clear, output empty.
`timescale 1ns / 1ps
`default_nettype none

module dds_header_checker
   import ddshc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   hdr_type     hdr;
   rsp_type     result;
   logic        req_accept;
   logic        fire_last;
   logic [31:0] file_bytes_ff, file_bytes_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   assign csr_ready  = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready || !hdr.at_last;
   assign req_accept = req_valid && req_ready;
   assign fire_last  = req_accept && hdr.at_last && !req_data.first;

   ddshc_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .hdr        (hdr)
   );

   ddshc_size u_size (
      .clock      (clock),
      .hdr        (hdr),
      .file_bytes (file_bytes_ff),
      .result     (result)
   );

   always_comb begin
      file_bytes_in = (csr_valid && csr_ready) ? csr_data : file_bytes_ff;
      rsp_data_in   = fire_last ? result : rsp_data_ff;
      priority if (fire_last) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_bytes_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         file_bytes_ff <= file_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ddshc_chk.sv =====
// Port-level checker for the DDS header checker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ddshc_chk
   import ddshc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire req_type     req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [31:0] csr_data
);

   // a waiting result holds until taken
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp item changed while stalled")

   // a result only appears after an accepted word
   `CHK_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready), "rsp item without an accepted word")

   // a good header gives a legal block size and borders
   `CHK_ASSERT(a_ok_fields, clock, reset, (rsp_valid && rsp_data.status == FAULT_NONE) |-> ((rsp_data.block_bytes == BLOCK_DXT1 || rsp_data.block_bytes == BLOCK_OTHER) && rsp_data.border_right != 3'd0 && rsp_data.border_bottom != 3'd0 && rsp_data.width != 32'd0), "bad fields on a good header")

   // a faulted header carries no sizes
   `CHK_ASSERT(a_fault_zero, clock, reset, (rsp_valid && rsp_data.status != FAULT_NONE) |-> (rsp_data.width == 32'd0 && rsp_data.data_bytes == 32'd0 && rsp_data.block_bytes == 5'd0), "faulted item carries sizes")

endmodule

bind dds_header_checker ddshc_chk u_ddshc_chk (.*);

`default_nettype wire
